>>> src/qacb_pkg.sv
package qacb_pkg;

    localparam int MAX_SIDE = 8;
    localparam int ROW_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CNT_W    = 8;
    localparam int SIDE_W   = 4;
    localparam int POS_W    = 3;
    // wide enough for side, positions and MAX_SIDE in compares
    localparam int EXT_W    = 6;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(8);
    localparam logic              REG_SIDE   = 1'b0;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_PLACE  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef logic signed [CNT_W-1:0] cnt_t;
    typedef logic signed [EXT_W:0]   dist_t;

    localparam cnt_t CNT_MAX = cnt_t'((2 ** (CNT_W - 1)) - 1);
    localparam cnt_t CNT_MIN = cnt_t'(-(2 ** (CNT_W - 1)));

    // one board row: queen flags and attack counts
    typedef struct packed {
        logic [MAX_SIDE-1:0] queen;
        cnt_t [MAX_SIDE-1:0] count;
    } row_t;

    typedef struct packed {
        logic load_item;
        logic clear;
        logic rd_item_row;
        logic eval;
        logic walk_start;
        logic walk_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_clear;
        logic modify;
        logic walk_last;
        logic out_free;
    } stat_t;

endpackage

>>> src/queen_attack_count_board.sv
// Attack-count board for N-queens search.
// Input channel (in_valid/in_ready) takes one item: op, col, row, check.
// Output channel (out_valid/out_ready) returns one item per input item:
// status, square_count (before the op) and queen_here.
// side is set over the APB port at address 0; write it only while idle.
// After acceptance an item passes the read and evaluate states; a place or
// remove that changes the board then walks every row of the side, one board row
// per cycle through the row memory, before the result is loaded. One item is
// in work at a time; the next item is taken the cycle after the result is
// loaded.
// The result sits in an output register: a stalled receiver holds it, and
// the block still takes and works the next item, waiting only to load its
// result until the register frees.
// Reset clears the board (per-row valid flags, no sweep), sets side to 8
// and empties the output register.
module queen_attack_count_board (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qacb_pkg::ADDR_W-1:0]    paddr,
    input  logic [qacb_pkg::DATA_W-1:0]    pwdata,
    output logic [qacb_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [qacb_pkg::POS_W-1:0]     col,
    input  logic [qacb_pkg::POS_W-1:0]     row,
    input  logic                           check,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           status,
    output logic signed [7:0]              square_count,
    output logic                           queen_here
);
    import qacb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign pready = 1'b1;

    qacb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qacb_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .op           (op),
        .col          (col),
        .row          (row),
        .check        (check),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .square_count (square_count),
        .queen_here   (queen_here),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule

>>> src/qacb_dp.sv
module qacb_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qacb_pkg::ADDR_W-1:0]    paddr,
    input  logic [qacb_pkg::DATA_W-1:0]    pwdata,
    output logic [qacb_pkg::DATA_W-1:0]    prdata,
    input  logic [1:0]                     op,
    input  logic [qacb_pkg::POS_W-1:0]     col,
    input  logic [qacb_pkg::POS_W-1:0]     row,
    input  logic                           check,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           status,
    output logic signed [7:0]              square_count,
    output logic                           queen_here,
    input  qacb_pkg::cmd_t                 cmd,
    output qacb_pkg::stat_t                stat
);
    import qacb_pkg::*;

    logic [SIDE_W-1:0]   side_reg;
    logic [EXT_W-1:0]    side_ext;
    logic [EXT_W-1:0]    eff_side;
    logic                cfg_wr;

    op_t                 op_reg;
    logic [POS_W-1:0]    x_reg;
    logic [POS_W-1:0]    y_reg;
    logic                chk_reg;
    logic                on_board;

    row_t                mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] row_valid_reg;
    row_t                rd_data_reg;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic [ROW_W-1:0]    walk_row_reg;
    row_t                row_new;

    cnt_t                cur_cnt;
    logic                cur_q;
    logic                res_status;
    cnt_t                res_cnt;
    logic                res_q;
    logic                modify;
    logic                res_status_reg;
    cnt_t                res_cnt_reg;
    logic                res_q_reg;

    logic                out_valid_reg;
    logic                out_status_reg;
    cnt_t                out_cnt_reg;
    logic                out_q_reg;

    // configuration
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1] == REG_SIDE);
    assign prdata = (paddr[ADDR_W-1] == REG_SIDE) ? DATA_W'(side_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
        end
        else if (cfg_wr)
        begin
            side_reg <= pwdata[SIDE_W-1:0];
        end
    end

    assign side_ext = EXT_W'(side_reg);
    assign eff_side = (side_ext == '0) ? EXT_W'(1) :
                      ((side_ext > EXT_W'(MAX_SIDE)) ? EXT_W'(MAX_SIDE) : side_ext);

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg  <= op_t'(op);
            x_reg   <= col;
            y_reg   <= row;
            chk_reg <= check;
        end
    end

    assign on_board = (EXT_W'(x_reg) < eff_side) && (EXT_W'(y_reg) < eff_side);

    // row memory: one read, one write per cycle
    assign stat.walk_last = (EXT_W'(walk_row_reg) + EXT_W'(1)) == eff_side;
    assign rd_en   = cmd.rd_item_row || cmd.walk_start || (cmd.walk_step && !stat.walk_last);
    assign rd_addr = cmd.rd_item_row ? ROW_W'(y_reg) :
                     (cmd.walk_start ? '0 : walk_row_reg + ROW_W'(1));

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= row_valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
        if (cmd.walk_step)
        begin
            mem[walk_row_reg] <= row_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            walk_row_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                row_valid_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                row_valid_reg[walk_row_reg] <= 1'b1;
            end
            if (cmd.walk_start)
            begin
                walk_row_reg <= '0;
            end
            else if (cmd.walk_step)
            begin
                walk_row_reg <= walk_row_reg + ROW_W'(1);
            end
        end
    end

    // update of the row under walk: row, column and both diagonals
    always_comb
    begin
        dist_t dj;
        dist_t di;
        logic  hit;
        logic  inc;
        cnt_t  c;
        dj      = dist_t'(walk_row_reg) - dist_t'(y_reg);
        inc     = (op_reg == OP_PLACE);
        row_new = rd_data_reg;
        for (int i = 0; i < MAX_SIDE; i++)
        begin
            di  = dist_t'(i) - dist_t'(x_reg);
            hit = (EXT_W'(i) < eff_side) &&
                  (di == '0 || dj == '0 || di == dj || di == -dj);
            c   = rd_data_reg.count[i];
            if (hit)
            begin
                if (inc && c != CNT_MAX)
                begin
                    row_new.count[i] = c + cnt_t'(1);
                end
                else if (!inc && c != CNT_MIN)
                begin
                    row_new.count[i] = c - cnt_t'(1);
                end
            end
        end
        if (dj == '0)
        begin
            row_new.queen[ROW_W'(x_reg)] = inc;
        end
    end

    // result of the addressed square
    assign cur_cnt = rd_data_reg.count[ROW_W'(x_reg)];
    assign cur_q   = rd_data_reg.queen[ROW_W'(x_reg)];

    always_comb
    begin
        res_status = 1'b0;
        res_cnt    = cur_cnt;
        res_q      = cur_q;
        modify     = 1'b0;
        if (!on_board)
        begin
            // clear still succeeds off the board
            res_status = (op_reg != OP_CLEAR);
            res_cnt    = '0;
            res_q      = 1'b0;
        end
        else
        begin
            case (op_reg)
                OP_QUERY:
                begin
                    res_status = (cur_cnt > cnt_t'(0));
                end
                OP_PLACE:
                begin
                    res_status = chk_reg && (cur_cnt > cnt_t'(0));
                    modify     = !res_status;
                end
                OP_REMOVE:
                begin
                    res_status = chk_reg && !cur_q;
                    modify     = !res_status;
                end
                default:
                begin
                    res_status = 1'b0;
                end
            endcase
        end
    end

    assign stat.modify   = modify;
    assign stat.in_clear = (op_reg == OP_CLEAR);

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            res_status_reg <= res_status;
            res_cnt_reg    <= res_cnt;
            res_q_reg      <= res_q;
        end
    end

    // output register
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_cnt_reg    <= res_cnt_reg;
            out_q_reg      <= res_q_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign square_count = out_cnt_reg;
    assign queen_here   = out_q_reg;

endmodule

>>> src/qacb_ctrl.sv
module qacb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qacb_pkg::stat_t stat,
    output qacb_pkg::cmd_t  cmd
);
    import qacb_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WALK,
        ST_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_item_row = 1'b1;
                state_next      = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                // clear reports the addressed square before wiping the board
                if (stat.in_clear)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_RESP;
                end
                else if (stat.modify)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = ST_WALK;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

>>> src/qacb_checker.sv
module qacb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           psel,
    input logic                           penable,
    input logic                           pwrite,
    input logic [qacb_pkg::ADDR_W-1:0]    paddr,
    input logic [qacb_pkg::DATA_W-1:0]    pwdata,
    input logic [qacb_pkg::DATA_W-1:0]    prdata,
    input logic                           pready,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic [1:0]                     op,
    input logic [qacb_pkg::POS_W-1:0]     col,
    input logic [qacb_pkg::POS_W-1:0]     row,
    input logic                           check,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           status,
    input logic signed [7:0]              square_count,
    input logic                           queen_here
);
    import qacb_pkg::*;

    // one item in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(square_count) && $stable(queen_here))
        else $error("result changed while stalled");

    // side readback follows the last write
    a_side_rd: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_SIDE)
        |=> (paddr[ADDR_W-1] != REG_SIDE)
            || (prdata[SIDE_W-1:0] == $past(pwdata[SIDE_W-1:0])))
        else $error("side readback mismatch");

endmodule

bind queen_attack_count_board qacb_checker u_qacb_checker (.*);

>>> tb/sv/queen_attack_count_board_test.sv
`timescale 1ns / 1ps

module queen_attack_count_board_test;
    import qacb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 30;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             chk;
    } req_t;

    typedef struct packed {
        logic status;
        cnt_t count;
        logic queen;
    } res_t;

    // how the random requests lean
    typedef enum int {
        MIX_SEARCH,
        MIX_PUMP_UP,
        MIX_PUMP_DOWN
    } mix_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [1:0]        op        = 2'b00;
    logic [POS_W-1:0]  col       = '0;
    logic [POS_W-1:0]  row       = '0;
    logic              check     = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              status;
    logic signed [7:0] square_count;
    logic              queen_here;

    // shadow board
    logic [SIDE_W-1:0] side_cfg = SIDE_RESET;
    logic              queen_map [MAX_SIDE*MAX_SIDE] = '{default: 1'b0};
    cnt_t              attack_cnt [MAX_SIDE*MAX_SIDE] = '{default: '0};

    req_t request_q [$];
    res_t board_results_q [$];
    int   placed_sq [$];
    int   err_count = 0;
    int   results_seen = 0;
    int   cycles = 0;
    bit   calm = 1'b0;
    bit   long_hold_req = 1'b0;

    queen_attack_count_board dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .col          (col),
        .row          (row),
        .check        (check),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .square_count (square_count),
        .queen_here   (queen_here)
    );

    always #5 clk = ~clk;

    function automatic int eff_side();
        if (side_cfg == 0)
            return 1;
        if (side_cfg > MAX_SIDE)
            return MAX_SIDE;
        return int'(side_cfg);
    endfunction

    function automatic void walk_lines(int x, int y, int s, int d);
        int dx;
        int dy;
        int v;
        for (int j = 0; j < s; j++)
        begin
            for (int i = 0; i < s; i++)
            begin
                dx = i - x;
                dy = j - y;
                if (dx == 0 || dy == 0 || dx == dy || dx == -dy)
                begin
                    v = int'(attack_cnt[j*MAX_SIDE+i]) + d;
                    if (v > CNT_MAX)
                        v = CNT_MAX;
                    if (v < CNT_MIN)
                        v = CNT_MIN;
                    attack_cnt[j*MAX_SIDE+i] = cnt_t'(v);
                end
            end
        end
    endfunction

    // applies one request to the shadow board, returns the item the block owes
    function automatic res_t board_step(req_t r);
        res_t res;
        int   s;
        int   x;
        int   y;
        int   idx;
        bit   on_board;
        res = '0;
        s = eff_side();
        x = int'(r.col);
        y = int'(r.row);
        idx = y * MAX_SIDE + x;
        on_board = x < s && y < s;
        if (on_board)
        begin
            res.count = attack_cnt[idx];
            res.queen = queen_map[idx];
        end
        if (r.op == OP_CLEAR)
        begin
            queen_map = '{default: 1'b0};
            attack_cnt = '{default: '0};
        end
        else if (!on_board)
            res.status = 1'b1;
        else
        begin
            case (r.op)
                OP_QUERY:
                    res.status = res.count > 0;
                OP_PLACE:
                    if (r.chk && res.count > 0)
                        res.status = 1'b1;
                    else
                    begin
                        queen_map[idx] = 1'b1;
                        walk_lines(x, y, s, 1);
                    end
                default:
                    if (r.chk && !res.queen)
                        res.status = 1'b1;
                    else
                    begin
                        queen_map[idx] = 1'b0;
                        walk_lines(x, y, s, -1);
                    end
            endcase
        end
        return res;
    endfunction

    task automatic note_error(string msg);
        $display("%0t: result %0d: %s", $time, results_seen, msg);
        err_count++;
    endtask

    task automatic queue_req(op_t o, int c, int r, bit k);
        req_t q;
        q.op = o;
        q.col = POS_W'(c);
        q.row = POS_W'(r);
        q.chk = k;
        request_q.push_back(q);
    endtask

    function automatic int pick_pos(int es);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, MAX_SIDE - 1);
        return $urandom_range(0, es - 1);
    endfunction

    task automatic push_random(int n, mix_t mix, int es);
        int  pick;
        int  k;
        int  sq;
        int  c;
        int  r;
        bit  chk;
        op_t o;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            c = pick_pos(es);
            r = pick_pos(es);
            chk = 1'($urandom_range(0, 1));
            o = OP_QUERY;
            if (mix == MIX_PUMP_UP || mix == MIX_PUMP_DOWN)
            begin
                if (pick < 90)
                begin
                    o = (mix == MIX_PUMP_UP) ? OP_PLACE : OP_REMOVE;
                    chk = 1'b0;
                end
                else if (pick < 95)
                    o = (mix == MIX_PUMP_UP) ? OP_REMOVE : OP_PLACE;
            end
            else if (pick < 3)
            begin
                o = OP_CLEAR;
                placed_sq.delete();
            end
            else if (pick < 15)
                o = OP_QUERY;
            else if (pick < 55)
            begin
                o = OP_PLACE;
                chk = 1'b1;
                placed_sq.push_back(c * MAX_SIDE + r);
            end
            else if (pick < 80)
            begin
                o = OP_REMOVE;
                chk = 1'b1;
                // mostly take back a queen we tried to place
                if (placed_sq.size() != 0 && $urandom_range(0, 3) != 0)
                begin
                    k = $urandom_range(0, placed_sq.size() - 1);
                    sq = placed_sq[k];
                    placed_sq.delete(k);
                    c = sq / MAX_SIDE;
                    r = sq % MAX_SIDE;
                end
            end
            else if (pick < 90)
            begin
                o = (pick < 85) ? OP_PLACE : OP_REMOVE;
                chk = 1'b0;
            end
            else
                o = op_t'($urandom_range(0, 3));
            queue_req(o, c, r, chk);
        end
    endtask

    task automatic write_side(int v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * REG_SIDE);
        pwdata <= DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        side_cfg = SIDE_W'(v);
    endtask

    // sampled at the falling edge so that every update of the rising edge is in
    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || board_results_q.size() != 0);
    endtask

    task automatic run_phase(int side_val, int n, mix_t mix, bit quiet, bit long_hold);
        write_side(side_val);
        @(negedge clk);
        calm = quiet;
        long_hold_req = long_hold;
        push_random(n, mix, eff_side());
        wait_idle();
    endtask

    always @(posedge clk)
    begin : drive_requests
        int   gap_left;
        req_t cur;
        req_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                board_results_q.push_back(board_step(cur));
                if (!calm && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 12);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() != 0)
                begin
                    nxt = request_q.pop_front();
                    cur = nxt;
                    in_valid <= 1'b1;
                    op <= nxt.op;
                    col <= nxt.col;
                    row <= nxt.row;
                    check <= nxt.chk;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : drive_ready
        int hold_left;
        bit long_done;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (long_hold_req && !long_done)
        begin
            // long stall: the block fills up and holds off its input
            long_done = 1'b1;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 15) == 0)
        begin
            hold_left = $urandom_range(1, 12) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (board_results_q.size() == 0)
                note_error("item with none expected");
            else
            begin
                want = board_results_q.pop_front();
                if (status !== want.status)
                    note_error($sformatf("status got %b want %b", status, want.status));
                if (square_count !== want.count)
                    note_error($sformatf("square_count got %0d want %0d",
                                         square_count, want.count));
                if (queen_here !== want.queen)
                    note_error($sformatf("queen_here got %b want %b",
                                         queen_here, want.queen));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[queen_attack_count_board] ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full board after reset
        queue_req(OP_QUERY, 0, 0, 1'b0);
        queue_req(OP_PLACE, 0, 0, 1'b1);
        queue_req(OP_QUERY, 7, 7, 1'b1);
        queue_req(OP_PLACE, 7, 7, 1'b1);   // attacked, refused
        queue_req(OP_PLACE, 7, 7, 1'b0);   // attacked, forced
        queue_req(OP_PLACE, 1, 2, 1'b1);
        queue_req(OP_PLACE, 0, 0, 1'b0);   // second queen on same square
        queue_req(OP_REMOVE, 3, 3, 1'b1);  // no queen, refused
        queue_req(OP_REMOVE, 3, 3, 1'b0);  // no queen, counts go negative
        queue_req(OP_QUERY, 3, 3, 1'b0);
        queue_req(OP_REMOVE, 0, 0, 1'b1);
        queue_req(OP_QUERY, 0, 7, 1'b0);
        queue_req(OP_PLACE, 7, 0, 1'b0);
        wait_idle();

        // shrink with queens still standing, then off-board requests
        write_side(3);
        @(negedge clk);
        queue_req(OP_QUERY, 2, 2, 1'b1);
        queue_req(OP_QUERY, 5, 6, 1'b0);
        queue_req(OP_PLACE, 3, 0, 1'b0);
        queue_req(OP_REMOVE, 0, 7, 1'b0);
        queue_req(OP_PLACE, 2, 2, 1'b0);
        queue_req(OP_REMOVE, 1, 2, 1'b1);
        queue_req(OP_CLEAR, 7, 7, 1'b1);
        queue_req(OP_QUERY, 0, 0, 1'b0);
        queue_req(OP_CLEAR, 1, 1, 1'b0);
        wait_idle();

        run_phase(8, 250, MIX_SEARCH, 1'b0, 1'b1);
        run_phase(5, 150, MIX_SEARCH, 1'b0, 1'b0);
        // tiny boards pump one square into saturation both ways
        run_phase(1, 180, MIX_PUMP_UP, 1'b0, 1'b0);
        run_phase(0, 380, MIX_PUMP_DOWN, 1'b0, 1'b0);
        run_phase(15, 250, MIX_SEARCH, 1'b0, 1'b0);
        run_phase(2, 120, MIX_SEARCH, 1'b0, 1'b0);
        run_phase(7, 200, MIX_SEARCH, 1'b0, 1'b0);
        run_phase(8, 150, MIX_SEARCH, 1'b1, 1'b0);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("[queen_attack_count_board] OK");
        else
            $display("[queen_attack_count_board] ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/qacb_pkg.sv
src/qacb_dp.sv
src/qacb_ctrl.sv
src/queen_attack_count_board.sv
src/qacb_checker.sv
tb/sv/queen_attack_count_board_test.sv
